// ===== hw/rtl/rfe_pkg.sv =====
package rfe_pkg;

  // Default largest surface side; larger width/height values saturate to it when clipping
  localparam int MAX_DIMENSION_DEF = 4096;

  // Signed width wide enough for all clipping sums of 15-bit coordinates
  localparam int CALC_W = 18;

  localparam int FMT_W   = 4;
  localparam int SIZE_W  = 13;
  localparam int PITCH_W = 15;
  localparam int ADDR_W  = 32;
  localparam int DATA_W  = 32;
  localparam int COORD_IN_W = 15;
  localparam int KIND_W  = 3;
  localparam int BPP_W   = 3;
  localparam int CFG_IDX_W = 3;

  typedef logic [FMT_W-1:0]  fmt_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [BPP_W-1:0]  bpp_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Pixel formats
  localparam fmt_t FMT_INDEX8 = 4'd0;
  localparam fmt_t FMT_RGB565 = 4'd1;
  localparam fmt_t FMT_RGB24  = 4'd2;
  localparam fmt_t FMT_BGR24  = 4'd3;
  localparam fmt_t FMT_XRGB   = 4'd4;
  localparam fmt_t FMT_XBGR   = 4'd8;
  localparam fmt_t FMT_BGRA   = 4'd11;

  // Result kinds
  localparam kind_t KIND_STARTED     = 3'd0;
  localparam kind_t KIND_NOTHING     = 3'd1;
  localparam kind_t KIND_UNSUPPORTED = 3'd2;
  localparam kind_t KIND_PIXEL       = 3'd3;
  localparam kind_t KIND_IDLE_TICK   = 3'd4;
  localparam kind_t KIND_BUSY        = 3'd5;

  // Configuration register indexes
  localparam cfg_idx_t CFG_PIXEL_FORMAT   = 3'd0;
  localparam cfg_idx_t CFG_SURFACE_WIDTH  = 3'd1;
  localparam cfg_idx_t CFG_SURFACE_HEIGHT = 3'd2;
  localparam cfg_idx_t CFG_ROW_PITCH      = 3'd3;
  localparam cfg_idx_t CFG_BASE_ADDRESS   = 3'd4;

  // Bytes per pixel: 2, 3 or 4; zero marks an unsupported format
  localparam bpp_t BPP_NONE = 3'd0;
  localparam bpp_t BPP_16   = 3'd2;
  localparam bpp_t BPP_24   = 3'd3;
  localparam bpp_t BPP_32   = 3'd4;

  // Reset values of the configuration registers
  localparam fmt_t               FMT_RESET    = FMT_XRGB;
  localparam logic [SIZE_W-1:0]  WIDTH_RESET  = 13'd640;
  localparam logic [SIZE_W-1:0]  HEIGHT_RESET = 13'd480;
  localparam logic [PITCH_W-1:0] PITCH_RESET  = 15'd2560;
  localparam logic [ADDR_W-1:0]  BASE_RESET   = 32'd0;

  function automatic bpp_t bytes_for_format(fmt_t fmt);
    bpp_t b;
    case (fmt) inside
      FMT_RGB565:           b = BPP_16;
      FMT_RGB24, FMT_BGR24: b = BPP_24;
      [FMT_XRGB:FMT_BGRA]:  b = BPP_32;
      default:              b = BPP_NONE;
    endcase
    return b;
  endfunction

  // Lay out the color in memory byte order, first byte in bits 7:0
  function automatic logic [DATA_W-1:0] pack_color(fmt_t fmt, logic [DATA_W-1:0] c);
    logic [DATA_W-1:0] p;
    case (fmt) inside
      [FMT_XBGR:FMT_BGRA]: p = {c[31:24], c[7:0], c[15:8], c[23:16]};
      FMT_BGR24:           p = {8'h00, c[23:0]};
      FMT_RGB24:           p = {8'h00, c[7:0], c[15:8], c[23:16]};
      FMT_RGB565:          p = {16'h0000, c[15:0]};
      default:             p = c;
    endcase
    return p;
  endfunction

endpackage

// ===== hw/rtl/rect_fill_engine_core.sv =====
// Rectangle fill engine: clips a start word to the surface, then emits one pixel write per tick.
// A word accepted lands in the input register; its result word is then presented from the
// result register (two register stages: input register, result register).
// Throughput: one word per cycle unless stalled; single multiply (row x pitch) in the result stage.
// Reset (rst_n low, synchronous): both stages empty, fill idle, registers at their defaults
// (xrgb, 640 x 480, pitch 2560, base 0).
module rect_fill_engine_core #(
  parameter int MAX_DIMENSION = rfe_pkg::MAX_DIMENSION_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_func,
  input  logic                                 in_whole_surface,
  input  logic signed [rfe_pkg::COORD_IN_W-1:0] in_rect_x,
  input  logic signed [rfe_pkg::COORD_IN_W-1:0] in_rect_y,
  input  logic signed [rfe_pkg::COORD_IN_W-1:0] in_rect_w,
  input  logic signed [rfe_pkg::COORD_IN_W-1:0] in_rect_h,
  input  logic        [rfe_pkg::DATA_W-1:0]    in_fill_color,

  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [rfe_pkg::KIND_W-1:0]    out_kind,
  output logic        [rfe_pkg::ADDR_W-1:0]    out_write_address,
  output logic        [rfe_pkg::DATA_W-1:0]    out_write_data,
  output logic        [rfe_pkg::BPP_W-1:0]     out_byte_count,
  output logic                                 out_last_pixel,

  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [rfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [rfe_pkg::DATA_W-1:0]    cfg_data
);

  // Column/row positions hold values below MAX_DIMENSION; ends may reach it
  localparam int COORD_W = $clog2(MAX_DIMENSION);
  localparam int DIM_W   = $clog2(MAX_DIMENSION + 1);
  localparam int CALC_W  = rfe_pkg::CALC_W;
  localparam int PROD_W  = COORD_W + rfe_pkg::PITCH_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. The port never pushes back.
  // ---------------------------------------------------------------------------
  rfe_pkg::fmt_t                      pixel_format_r;
  logic [rfe_pkg::SIZE_W-1:0]         surface_width_r;
  logic [rfe_pkg::SIZE_W-1:0]         surface_height_r;
  logic [rfe_pkg::PITCH_W-1:0]        row_pitch_r;
  logic [rfe_pkg::ADDR_W-1:0]         base_address_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r   <= rfe_pkg::FMT_RESET;
      surface_width_r  <= rfe_pkg::WIDTH_RESET;
      surface_height_r <= rfe_pkg::HEIGHT_RESET;
      row_pitch_r      <= rfe_pkg::PITCH_RESET;
      base_address_r   <= rfe_pkg::BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rfe_pkg::CFG_PIXEL_FORMAT:   pixel_format_r   <= cfg_data[rfe_pkg::FMT_W-1:0];
        rfe_pkg::CFG_SURFACE_WIDTH:  surface_width_r  <= cfg_data[rfe_pkg::SIZE_W-1:0];
        rfe_pkg::CFG_SURFACE_HEIGHT: surface_height_r <= cfg_data[rfe_pkg::SIZE_W-1:0];
        rfe_pkg::CFG_ROW_PITCH:      row_pitch_r      <= cfg_data[rfe_pkg::PITCH_W-1:0];
        rfe_pkg::CFG_BASE_ADDRESS:   base_address_r   <= cfg_data;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register. It drains whenever the result register can load,
  // so a new word is taken every cycle unless the result side is stalled.
  // ---------------------------------------------------------------------------
  logic                                  inq_valid_r;
  logic                                  inq_func_r;
  logic                                  inq_whole_r;
  logic signed [rfe_pkg::COORD_IN_W-1:0] inq_x_r, inq_y_r, inq_w_r, inq_h_r;
  logic        [rfe_pkg::DATA_W-1:0]     inq_color_r;

  logic advance;   // stage-1 word moves into the result register this edge
  logic out_valid_r;

  assign advance  = inq_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = inq_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (!in_stall) begin
      inq_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      inq_func_r  <= in_func;
      inq_whole_r <= in_whole_surface;
      inq_x_r     <= in_rect_x;
      inq_y_r     <= in_rect_y;
      inq_w_r     <= in_rect_w;
      inq_h_r     <= in_rect_h;
      inq_color_r <= in_fill_color;
    end
  end

  // ---------------------------------------------------------------------------
  // Fill state. Updated only when a stage-1 word advances, so the next word
  // in stage 1 always sees the state left by its predecessor.
  // ---------------------------------------------------------------------------
  logic                          fill_active_r, fill_active_nxt;
  logic [COORD_W-1:0]            cur_col_r, cur_col_nxt;
  logic [COORD_W-1:0]            cur_row_r, cur_row_nxt;
  logic [COORD_W-1:0]            first_col_r, first_col_nxt;
  logic [DIM_W-1:0]              end_col_r, end_col_nxt;
  logic [DIM_W-1:0]              end_row_r, end_row_nxt;
  logic [rfe_pkg::DATA_W-1:0]    pattern_r, pattern_nxt;
  rfe_pkg::bpp_t                 pixel_bytes_r, pixel_bytes_nxt;

  // ---------------------------------------------------------------------------
  // Start path: clip the rectangle against the saturated surface size.
  // ---------------------------------------------------------------------------
  logic signed [CALC_W-1:0] max_dim;
  logic signed [CALC_W-1:0] sw, sh;
  logic signed [CALC_W-1:0] x0, y0, w0, h0;
  logic signed [CALC_W-1:0] x1, y1, w1, h1;
  logic signed [CALC_W-1:0] w2, h2;
  logic signed [CALC_W-1:0] x_end, y_end;
  logic                     clip_empty;
  rfe_pkg::bpp_t            start_bpp;

  always_comb begin
    max_dim = CALC_W'(MAX_DIMENSION);
    sw = signed'(CALC_W'(surface_width_r));
    sh = signed'(CALC_W'(surface_height_r));
    if (sw > max_dim) sw = max_dim;
    if (sh > max_dim) sh = max_dim;

    if (inq_whole_r) begin
      x0 = '0;
      y0 = '0;
      w0 = sw;
      h0 = sh;
    end else begin
      x0 = CALC_W'(inq_x_r);
      y0 = CALC_W'(inq_y_r);
      w0 = CALC_W'(inq_w_r);
      h0 = CALC_W'(inq_h_r);
    end

    // Pull a negative origin to zero, shrinking the extent by the same amount
    x1 = (x0 < 0) ? '0 : x0;
    w1 = (x0 < 0) ? w0 + x0 : w0;
    y1 = (y0 < 0) ? '0 : y0;
    h1 = (y0 < 0) ? h0 + y0 : h0;

    // Trim the far edge to the surface
    w2 = (x1 + w1 > sw) ? sw - x1 : w1;
    h2 = (y1 + h1 > sh) ? sh - y1 : h1;

    x_end = x1 + w2;
    y_end = y1 + h2;

    clip_empty = (w2 <= 0) || (h2 <= 0);
    start_bpp  = rfe_pkg::bytes_for_format(pixel_format_r);
  end

  // ---------------------------------------------------------------------------
  // Tick path: address of the current pixel and the raster step.
  // ---------------------------------------------------------------------------
  logic [rfe_pkg::PITCH_W-1:0] pitch_eff;
  logic [PROD_W-1:0]           row_offset;
  logic [rfe_pkg::ADDR_W-1:0]  col_offset;
  logic [rfe_pkg::ADDR_W-1:0]  pixel_addr;
  logic [DIM_W-1:0]            col_inc, row_inc;
  logic                        row_done, fill_done;

  always_comb begin
    // Round the pitch down to whole pixels for 16- and 32-bit layouts
    case (pixel_bytes_r)
      rfe_pkg::BPP_32: pitch_eff = {row_pitch_r[rfe_pkg::PITCH_W-1:2], 2'b00};
      rfe_pkg::BPP_16: pitch_eff = {row_pitch_r[rfe_pkg::PITCH_W-1:1], 1'b0};
      default:         pitch_eff = row_pitch_r;
    endcase

    row_offset = PROD_W'(cur_row_r) * PROD_W'(pitch_eff);

    case (pixel_bytes_r)
      rfe_pkg::BPP_16: col_offset = rfe_pkg::ADDR_W'(cur_col_r) << 1;
      rfe_pkg::BPP_24: col_offset = (rfe_pkg::ADDR_W'(cur_col_r) << 1)
                                    + rfe_pkg::ADDR_W'(cur_col_r);
      rfe_pkg::BPP_32: col_offset = rfe_pkg::ADDR_W'(cur_col_r) << 2;
      default:         col_offset = '0;
    endcase

    pixel_addr = base_address_r + rfe_pkg::ADDR_W'(row_offset) + col_offset;

    col_inc   = DIM_W'(cur_col_r) + DIM_W'(1);
    row_inc   = DIM_W'(cur_row_r) + DIM_W'(1);
    row_done  = (col_inc >= end_col_r);
    fill_done = row_done && (row_inc >= end_row_r);
  end

  // ---------------------------------------------------------------------------
  // Result and next-state selection.
  // ---------------------------------------------------------------------------
  rfe_pkg::kind_t              kind_nxt;
  logic [rfe_pkg::ADDR_W-1:0]  addr_nxt;
  logic [rfe_pkg::DATA_W-1:0]  data_nxt;
  rfe_pkg::bpp_t               count_nxt;
  logic                        last_nxt;

  always_comb begin
    fill_active_nxt = fill_active_r;
    cur_col_nxt     = cur_col_r;
    cur_row_nxt     = cur_row_r;
    first_col_nxt   = first_col_r;
    end_col_nxt     = end_col_r;
    end_row_nxt     = end_row_r;
    pattern_nxt     = pattern_r;
    pixel_bytes_nxt = pixel_bytes_r;

    kind_nxt  = rfe_pkg::KIND_IDLE_TICK;
    addr_nxt  = '0;
    data_nxt  = '0;
    count_nxt = '0;
    last_nxt  = 1'b0;

    if (!inq_func_r) begin
      if (fill_active_r) begin
        kind_nxt = rfe_pkg::KIND_BUSY;
      end else if (clip_empty) begin
        kind_nxt = rfe_pkg::KIND_NOTHING;
      end else if (start_bpp == rfe_pkg::BPP_NONE) begin
        kind_nxt = rfe_pkg::KIND_UNSUPPORTED;
      end else begin
        kind_nxt        = rfe_pkg::KIND_STARTED;
        fill_active_nxt = 1'b1;
        pattern_nxt     = rfe_pkg::pack_color(pixel_format_r, inq_color_r);
        pixel_bytes_nxt = start_bpp;
        first_col_nxt   = COORD_W'(x1);
        cur_col_nxt     = COORD_W'(x1);
        cur_row_nxt     = COORD_W'(y1);
        end_col_nxt     = DIM_W'(x_end);
        end_row_nxt     = DIM_W'(y_end);
      end
    end else if (fill_active_r) begin
      kind_nxt  = rfe_pkg::KIND_PIXEL;
      addr_nxt  = pixel_addr;
      data_nxt  = pattern_r;
      count_nxt = pixel_bytes_r;
      last_nxt  = fill_done;
      if (row_done) begin
        cur_col_nxt = first_col_r;
        cur_row_nxt = COORD_W'(row_inc);
        if (fill_done) fill_active_nxt = 1'b0;
      end else begin
        cur_col_nxt = COORD_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_active_r <= 1'b0;
    end else if (advance) begin
      fill_active_r <= fill_active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cur_col_r     <= cur_col_nxt;
      cur_row_r     <= cur_row_nxt;
      first_col_r   <= first_col_nxt;
      end_col_r     <= end_col_nxt;
      end_row_r     <= end_row_nxt;
      pattern_r     <= pattern_nxt;
      pixel_bytes_r <= pixel_bytes_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: result register. Load on advance, hold while stalled.
  // ---------------------------------------------------------------------------
  rfe_pkg::kind_t              out_kind_r;
  logic [rfe_pkg::ADDR_W-1:0]  out_addr_r;
  logic [rfe_pkg::DATA_W-1:0]  out_data_r;
  rfe_pkg::bpp_t               out_count_r;
  logic                        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind_r  <= kind_nxt;
      out_addr_r  <= addr_nxt;
      out_data_r  <= data_nxt;
      out_count_r <= count_nxt;
      out_last_r  <= last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_write_address = out_addr_r;
  assign out_write_data    = out_data_r;
  assign out_byte_count    = out_count_r;
  assign out_last_pixel    = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // The raster position stays inside the clipped rectangle while filling
  a_pos_in_rect: assert property (@(posedge clk) disable iff (!rst_n)
    fill_active_r |-> (DIM_W'(cur_col_r) < end_col_r) && (DIM_W'(cur_row_r) < end_row_r))
    else $error("raster position outside the clipped rectangle");

  // An active fill always carries a supported pixel size
  a_bpp_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fill_active_r |-> (pixel_bytes_r == rfe_pkg::BPP_16) || (pixel_bytes_r == rfe_pkg::BPP_24)
                      || (pixel_bytes_r == rfe_pkg::BPP_32))
    else $error("active fill without a supported pixel size");

  // A fill starts only together with a fill-started result
  a_start_reported: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fill_active_r) |-> out_valid_r && (out_kind_r == rfe_pkg::KIND_STARTED))
    else $error("fill became active without a start result");

  // A fill ends only with a pixel write marked last
  a_end_marked: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(fill_active_r) |->
      out_valid_r && (out_kind_r == rfe_pkg::KIND_PIXEL) && out_last_r)
    else $error("fill ended without a last pixel write");

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rfe_pkg::*;

  // Start and tick share one func bit on the input channel
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Format codes the package leaves unnamed: the "other" range, lowest and highest
  localparam fmt_t FMT_OTHER_LOW = 4'd12;
  localparam fmt_t FMT_OTHER_TOP = 4'd15;

  // First and last register index past the end of the register file; writes there are dropped
  localparam cfg_idx_t CFG_UNUSED_FIRST = 3'd5;
  localparam cfg_idx_t CFG_UNUSED_LAST  = 3'd7;

  localparam int MAX_SIDE      = MAX_DIMENSION_DEF;
  localparam int WORD_TARGET   = 1550;
  localparam int RETUNE_EVERY  = 40;      // words sent while no fill runs, between register phases
  localparam int SETTLE_CYCLES = 4;       // two register stages plus margin
  localparam int CYCLE_LIMIT   = 400000;
  localparam int IDLE_PERCENT  = 33;
  localparam int STEADY_FIRST  = 700;     // words in [STEADY_FIRST, STEADY_LAST) never idle
  localparam int STEADY_LAST   = 1000;

  // One result word as the block presents it
  typedef struct packed {
    kind_t              kind;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  data;
    bpp_t               count;
    logic               last;
  } fill_result_t;

  // Directed plan: either an input word or a register write
  typedef enum logic {ROW_WORD, ROW_CFG} row_op_e;

  typedef struct packed {
    row_op_e                 op;
    logic                    func;
    logic                    whole;
    logic [COORD_IN_W-1:0]   x;
    logic [COORD_IN_W-1:0]   y;
    logic [COORD_IN_W-1:0]   w;
    logic [COORD_IN_W-1:0]   h;
    logic [DATA_W-1:0]       color;
    logic                    typed;      // expected kind written into the row itself
    kind_t                   exp_kind;
    cfg_idx_t                idx;
    logic [DATA_W-1:0]       value;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_func = FUNC_TICK;
  logic                          in_whole_surface = 1'b0;
  logic signed [COORD_IN_W-1:0]  in_rect_x = '0;
  logic signed [COORD_IN_W-1:0]  in_rect_y = '0;
  logic signed [COORD_IN_W-1:0]  in_rect_w = '0;
  logic signed [COORD_IN_W-1:0]  in_rect_h = '0;
  logic        [DATA_W-1:0]      in_fill_color = '0;

  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic        [KIND_W-1:0]      out_kind;
  logic        [ADDR_W-1:0]      out_write_address;
  logic        [DATA_W-1:0]      out_write_data;
  logic        [BPP_W-1:0]       out_byte_count;
  logic                          out_last_pixel;

  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic        [CFG_IDX_W-1:0]   cfg_index = '0;
  logic        [DATA_W-1:0]      cfg_data = '0;

  rect_fill_engine_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_whole_surface  (in_whole_surface),
    .in_rect_x         (in_rect_x),
    .in_rect_y         (in_rect_y),
    .in_rect_w         (in_rect_w),
    .in_rect_h         (in_rect_h),
    .in_fill_color     (in_fill_color),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_byte_count    (out_byte_count),
    .out_last_pixel    (out_last_pixel),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the engine: registers and fill walker
  // ---------------------------------------------------------------------------
  fmt_t               fmt_r   = FMT_RESET;
  logic [SIZE_W-1:0]  width_r  = WIDTH_RESET;
  logic [SIZE_W-1:0]  height_r = HEIGHT_RESET;
  logic [PITCH_W-1:0] pitch_r  = PITCH_RESET;
  logic [ADDR_W-1:0]  base_r   = BASE_RESET;

  logic               filling   = 1'b0;
  logic [12:0]        cur_col   = '0;
  logic [12:0]        cur_row   = '0;
  logic [12:0]        col_first = '0;
  logic [12:0]        col_end   = '0;
  logic [12:0]        row_end   = '0;
  logic [DATA_W-1:0]  pattern   = '0;
  bpp_t               pix_bytes = BPP_NONE;

  fill_result_t pending_results[$];
  plan_row_t    fill_plan[$];

  int          error_count = 0;
  int          cycle_count = 0;
  int unsigned words_sent  = 0;
  logic        steady      = 1'b0;

  function automatic bpp_t format_bytes(input fmt_t f);
    if (f == FMT_RGB565) return BPP_16;
    if (f == FMT_RGB24 || f == FMT_BGR24) return BPP_24;
    if (f >= FMT_XRGB && f <= FMT_BGRA) return BPP_32;
    return BPP_NONE;
  endfunction

  // Surface sides above the maximum saturate
  function automatic int clamp_side(input logic [SIZE_W-1:0] s);
    return (s > MAX_SIDE) ? MAX_SIDE : int'(s);
  endfunction

  // Advance the shadow engine by one input word and return the word it owes
  function automatic fill_result_t advance_fill(input logic func, input logic whole,
      input logic signed [COORD_IN_W-1:0] rx, input logic signed [COORD_IN_W-1:0] ry,
      input logic signed [COORD_IN_W-1:0] rw, input logic signed [COORD_IN_W-1:0] rh,
      input logic [DATA_W-1:0] color);
    fill_result_t res;
    int sw, sh, x, y, w, h;
    bpp_t pix;
    logic [DATA_W-1:0] c;
    logic [ADDR_W-1:0] pitch_eff;
    res = '0;
    if (func == FUNC_START) begin
      if (filling) begin
        res.kind = KIND_BUSY;
      end else begin
        sw = clamp_side(width_r);
        sh = clamp_side(height_r);
        if (whole) begin
          x = 0; y = 0; w = sw; h = sh;
        end else begin
          x = rx; y = ry; w = rw; h = rh;
        end
        // Clip left/top edges first, then right/bottom
        if (x < 0) begin
          w = w + x;
          x = 0;
        end
        if (y < 0) begin
          h = h + y;
          y = 0;
        end
        if (x + w > sw) w = sw - x;
        if (y + h > sh) h = sh - y;
        pix = format_bytes(fmt_r);
        if (w <= 0 || h <= 0) begin
          res.kind = KIND_NOTHING;
        end else if (pix == BPP_NONE) begin
          res.kind = KIND_UNSUPPORTED;
        end else begin
          c = color;
          case (pix)
            BPP_32: begin
              if (fmt_r >= FMT_XBGR)
                c = (c & 32'hFF00FF00) | ((c & 32'h00FF0000) >> 16) | ((c & 32'h000000FF) << 16);
            end
            BPP_24: begin
              if (fmt_r == FMT_BGR24) c = c & 32'h00FFFFFF;
              else c = {8'h00, color[7:0], color[15:8], color[23:16]};
            end
            default: c = c & 32'h0000FFFF;
          endcase
          pattern   = c;
          pix_bytes = pix;
          col_first = x;
          cur_col   = x;
          cur_row   = y;
          col_end   = x + w;
          row_end   = y + h;
          filling   = 1'b1;
          res.kind  = KIND_STARTED;
        end
      end
    end else if (!filling) begin
      res.kind = KIND_IDLE_TICK;
    end else begin
      // Pitch drops to a whole number of pixels for 16- and 32-bit layouts
      pitch_eff = pitch_r;
      if (pix_bytes == BPP_32) pitch_eff[1:0] = 2'b00;
      else if (pix_bytes == BPP_16) pitch_eff[0] = 1'b0;
      res.kind  = KIND_PIXEL;
      res.addr  = base_r + cur_row * pitch_eff + cur_col * pix_bytes;
      res.data  = pattern;
      res.count = pix_bytes;
      if (cur_col + 13'd1 >= col_end) begin
        cur_col = col_first;
        cur_row = cur_row + 13'd1;
        if (cur_row >= row_end) begin
          res.last = 1'b1;
          filling  = 1'b0;
        end
      end else begin
        cur_col = cur_col + 13'd1;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed plan builders
  // ---------------------------------------------------------------------------
  function automatic void add_word(input logic func, input logic whole,
      input int x, input int y, input int w, input int h, input logic [DATA_W-1:0] color,
      input logic typed, input kind_t exp_kind);
    plan_row_t r;
    r = '0;
    r.op = ROW_WORD;
    r.func = func;
    r.whole = whole;
    r.x = x;
    r.y = y;
    r.w = w;
    r.h = h;
    r.color = color;
    r.typed = typed;
    r.exp_kind = exp_kind;
    fill_plan.push_back(r);
  endfunction

  function automatic void add_cfg(input cfg_idx_t idx, input logic [DATA_W-1:0] value);
    plan_row_t r;
    r = '0;
    r.op = ROW_CFG;
    r.idx = idx;
    r.value = value;
    fill_plan.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Present one word, hold it through stalls, then log what the engine owes for it
  task automatic send_word(input logic func, input logic whole,
      input logic [COORD_IN_W-1:0] x, input logic [COORD_IN_W-1:0] y,
      input logic [COORD_IN_W-1:0] w, input logic [COORD_IN_W-1:0] h,
      input logic [DATA_W-1:0] color, input logic typed, input kind_t exp_kind);
    fill_result_t res;
    if (cfg_valid) cfg_valid <= 1'b0;
    steady = (words_sent >= STEADY_FIRST && words_sent < STEADY_LAST);
    // Random gap ahead of the word
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= func;
    in_whole_surface <= whole;
    in_rect_x        <= x;
    in_rect_y        <= y;
    in_rect_w        <= w;
    in_rect_h        <= h;
    in_fill_color    <= color;
    do @(posedge clk); while (in_stall);
    words_sent++;
    res = advance_fill(func, whole, x, y, w, h, color);
    if (typed) begin
      res = '0;
      res.kind = exp_kind;
    end
    pending_results.push_back(res);
  endtask

  // Drop the input valid and wait for every owed word plus the pipeline depth
  task automatic settle_block();
    in_valid <= 1'b0;
    if (cfg_valid) cfg_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hold one register write until the port takes it; valid stays high for the next write
  task automatic write_register(input cfg_idx_t idx, input logic [DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PIXEL_FORMAT:   fmt_r    = value[FMT_W-1:0];
      CFG_SURFACE_WIDTH:  width_r  = value[SIZE_W-1:0];
      CFG_SURFACE_HEIGHT: height_r = value[SIZE_W-1:0];
      CFG_ROW_PITCH:      pitch_r  = value[PITCH_W-1:0];
      CFG_BASE_ADDRESS:   base_r   = value;
      default: ;
    endcase
  endtask

  function automatic logic [SIZE_W-1:0] pick_side();
    case ($urandom_range(9))
      0:       return '0;
      1:       return SIZE_W'(MAX_SIDE);
      2:       return $urandom_range(MAX_SIDE + 1, (1 << SIZE_W) - 1);
      3:       return 1;
      default: return $urandom_range(2, 12);
    endcase
  endfunction

  // Register phase: rewrite a random subset of registers, upper data bits randomized
  task automatic retune_surface();
    logic [DATA_W-1:0] v;
    settle_block();
    if ($urandom_range(2) != 0) begin
      if ($urandom_range(3) == 0) v = $urandom_range(0, (1 << FMT_W) - 1);
      else v = $urandom_range(FMT_RGB565, FMT_BGRA);
      write_register(CFG_PIXEL_FORMAT, ($urandom & ~32'h0000000F) | v);
    end
    if ($urandom_range(2) != 0)
      write_register(CFG_SURFACE_WIDTH, ($urandom & ~32'h00001FFF) | pick_side());
    if ($urandom_range(2) != 0)
      write_register(CFG_SURFACE_HEIGHT, ($urandom & ~32'h00001FFF) | pick_side());
    if ($urandom_range(2) != 0) begin
      case ($urandom_range(4))
        0:       v = '0;
        1:       v = (1 << PITCH_W) - 1;
        default: v = $urandom_range(0, (1 << PITCH_W) - 1);
      endcase
      write_register(CFG_ROW_PITCH, ($urandom & ~32'h00007FFF) | v);
    end
    if ($urandom_range(2) != 0) begin
      case ($urandom_range(4))
        0:       v = '0;
        1:       v = '1;
        default: v = $urandom;
      endcase
      write_register(CFG_BASE_ADDRESS, v);
    end
    // Writes past the register file must not disturb anything
    if ($urandom_range(4) == 0)
      write_register(cfg_idx_t'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)), $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure, with a steady stretch in the middle of the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
  end

  // Compare each accepted result word with the oldest owed one
  always @(posedge clk) begin : check_results
    fill_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result word with nothing owed, kind %0d", out_kind));
      end else begin
        want = pending_results.pop_front();
        if (out_kind !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", out_kind, want.kind));
        if (out_write_address !== want.addr)
          report_mismatch($sformatf("write_address %h, expected %h",
                                    out_write_address, want.addr));
        if (out_write_data !== want.data)
          report_mismatch($sformatf("write_data %h, expected %h", out_write_data, want.data));
        if (out_byte_count !== want.count)
          report_mismatch($sformatf("byte_count %0d, expected %0d",
                                    out_byte_count, want.count));
        if (out_last_pixel !== want.last)
          report_mismatch($sformatf("last_pixel %b, expected %b", out_last_pixel, want.last));
      end
    end
  end

  // Hard stop if the engine hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int roll, swc, shc, seq;
    logic [COORD_IN_W-1:0] rx, ry, rw, rh;

    // Reset-default surface: xrgb, 640 x 480, pitch 2560, base 0
    add_word(FUNC_TICK, 0, 0, 0, 0, 0, 32'h0, 1, KIND_IDLE_TICK);
    add_word(FUNC_START, 0, 10, 10, 0, 5, 32'h0, 1, KIND_NOTHING);
    add_word(FUNC_START, 0, -16384, -16384, 16383, 16383, 32'hFFFFFFFF, 1, KIND_NOTHING);
    add_word(FUNC_START, 0, 16383, 0, 16383, 1, 32'h0, 1, KIND_NOTHING);
    // Bottom-right corner, clipped down to 2 x 2
    add_word(FUNC_START, 0, 638, 478, 16383, 16383, 32'h12345678, 1, KIND_STARTED);
    add_word(FUNC_START, 1, 0, 0, 1, 1, 32'h0, 1, KIND_BUSY);
    repeat (4) add_word(FUNC_TICK, 0, -1, -1, -1, -1, 32'hFFFFFFFF, 0, KIND_PIXEL);

    // Tiny surface, odd maximum pitch, base near the top of the address space
    add_cfg(CFG_PIXEL_FORMAT, FMT_INDEX8);
    add_cfg(CFG_SURFACE_WIDTH, 3);
    add_cfg(CFG_SURFACE_HEIGHT, 2);
    add_cfg(CFG_ROW_PITCH, (1 << PITCH_W) - 1);
    add_cfg(CFG_BASE_ADDRESS, 32'hFFFFFFF0);
    add_word(FUNC_START, 1, -1, -1, -1, -1, 32'h0, 1, KIND_UNSUPPORTED);
    // Empty clip wins over an unsupported format
    add_word(FUNC_START, 0, 5, 0, 1, 1, 32'h0, 1, KIND_NOTHING);
    add_cfg(CFG_PIXEL_FORMAT, FMT_OTHER_TOP);
    add_word(FUNC_START, 1, 0, 0, 1, 1, 32'h0, 1, KIND_UNSUPPORTED);

    // Whole 3 x 2 surface in bgra: red/blue swap and address wrap
    add_cfg(CFG_PIXEL_FORMAT, FMT_BGRA);
    add_word(FUNC_START, 1, 16383, -16384, -16384, 16383, 32'hA1B2C3D4, 1, KIND_STARTED);
    repeat (6) add_word(FUNC_TICK, 0, 0, 0, 0, 0, 32'h0, 0, KIND_PIXEL);

    // Zero width empties every rectangle
    add_cfg(CFG_SURFACE_WIDTH, 0);
    add_word(FUNC_START, 1, 0, 0, 1, 1, 32'h0, 1, KIND_NOTHING);

    // Oversized width saturates; fill the last two columns in rgb24 with zero pitch
    add_cfg(CFG_SURFACE_WIDTH, (1 << SIZE_W) - 1);
    add_cfg(CFG_SURFACE_HEIGHT, 1);
    add_cfg(CFG_PIXEL_FORMAT, FMT_RGB24);
    add_cfg(CFG_ROW_PITCH, 0);
    add_word(FUNC_START, 0, MAX_SIDE - 2, 0, 16383, 1, 32'h5A6B7C8D, 1, KIND_STARTED);
    repeat (2) add_word(FUNC_TICK, 0, 0, 0, 0, 0, 32'h0, 0, KIND_PIXEL);
    add_word(FUNC_TICK, 0, 0, 0, 0, 0, 32'h0, 1, KIND_IDLE_TICK);
    add_cfg(CFG_UNUSED_FIRST, 32'hFFFFFFFF);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (fill_plan[i]) begin
      if (fill_plan[i].op == ROW_CFG) begin
        settle_block();
        write_register(fill_plan[i].idx, fill_plan[i].value);
      end else begin
        send_word(fill_plan[i].func, fill_plan[i].whole, fill_plan[i].x, fill_plan[i].y,
                  fill_plan[i].w, fill_plan[i].h, fill_plan[i].color,
                  fill_plan[i].typed, fill_plan[i].exp_kind);
      end
    end

    // Random part: mostly small fills walked to completion, with noise around them
    seq = 0;
    while (words_sent < WORD_TARGET || filling) begin
      roll = $urandom_range(99);
      if (filling) begin
        // Poke the running fill with an early start now and then
        if (roll < 8)
          send_word(FUNC_START, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, 0, KIND_PIXEL);
        else
          send_word(FUNC_TICK, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, 0, KIND_PIXEL);
      end else begin
        swc = clamp_side(width_r);
        shc = clamp_side(height_r);
        if (format_bytes(fmt_r) == BPP_NONE || swc == 0 || shc == 0) begin
          // No fill can start here: hit the clipper with full-range rectangles
          send_word(roll < 15 ? FUNC_TICK : FUNC_START, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, 0, KIND_PIXEL);
        end else if (roll < 10) begin
          send_word(FUNC_TICK, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, 0, KIND_PIXEL);
        end else if (roll < 20 && swc * shc <= 48) begin
          send_word(FUNC_START, 1'b1, $urandom, $urandom, $urandom, $urandom,
                    $urandom, 0, KIND_PIXEL);
        end else begin
          // Small rectangle around the surface, often hanging over an edge
          rx = $urandom_range(0, swc + 10) - 8;
          ry = $urandom_range(0, shc + 10) - 8;
          rw = $urandom_range(0, 12) - 3;
          rh = $urandom_range(0, 9) - 3;
          send_word(FUNC_START, 1'b0, rx, ry, rw, rh, $urandom, 0, KIND_PIXEL);
        end
        seq++;
        if (seq % RETUNE_EVERY == 0 && !filling && words_sent < WORD_TARGET)
          retune_surface();
      end
    end

    settle_block();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== rect_fill_engine_core.f =====
hw/rtl/rfe_pkg.sv
hw/rtl/rect_fill_engine_core.sv
verif/testbench.sv
